@@ hdl/aes_xcbc_message_auth_macros.svh @@
// Assertion macros shared by the checker of the XCBC MAC block.
`ifndef AES_XCBC_MESSAGE_AUTH_MACROS_SVH
`define AES_XCBC_MESSAGE_AUTH_MACROS_SVH

// Same-cycle implication, reset-qualified.
`define AXM_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, reset-qualified.
`define AXM_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ hdl/axm_pkg.sv @@
// Package of the XCBC MAC block: AES tables, round functions, command types.
package axm_pkg;

  localparam int unsigned LastRound = 10;
  localparam int unsigned CfgIdxW   = 2;

  localparam logic [CfgIdxW-1:0] CFG_KEY_HIGH = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_KEY_LOW  = 2'd1;

  // Subkey selectors; the derivation constant byte is selector + 1.
  localparam logic [1:0] SK_ONE   = 2'd0;
  localparam logic [1:0] SK_TWO   = 2'd1;
  localparam logic [1:0] SK_THREE = 2'd2;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DLOAD,
    ST_DERIVE,
    ST_RUN,
    ST_FIN
  } axm_state_e;

  typedef struct packed {
    logic       ld_const;
    logic       ld_block;
    logic [1:0] sk_sel;
    logic       round_en;
    logic       store_sub;
    logic       store_chain;
    logic       store_mac;
    logic       clr_chain;
  } axm_cmd_t;

  typedef struct packed {
    logic last_round;
  } axm_sts_t;

  localparam logic [7:0] SBOX [256] = '{
    8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
    8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
    8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
    8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
    8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
    8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
    8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
    8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
    8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
    8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
    8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
    8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
    8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
    8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
    8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
    8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
  };

  function automatic logic [7:0] rcon(input logic [3:0] rnd);
    logic [7:0] r;
    unique case (rnd)
      4'd1:    r = 8'h01;
      4'd2:    r = 8'h02;
      4'd3:    r = 8'h04;
      4'd4:    r = 8'h08;
      4'd5:    r = 8'h10;
      4'd6:    r = 8'h20;
      4'd7:    r = 8'h40;
      4'd8:    r = 8'h80;
      4'd9:    r = 8'h1b;
      4'd10:   r = 8'h36;
      default: r = 8'h00;
    endcase
    return r;
  endfunction

  function automatic logic [7:0] xtime(input logic [7:0] x);
    return {x[6:0], 1'b0} ^ (x[7] ? 8'h1b : 8'h00);
  endfunction

  // Next round key from the current one; word 0 is the most significant.
  function automatic logic [127:0] key_next(input logic [127:0] k, input logic [3:0] rnd);
    logic [31:0] t;
    logic [31:0] w0, w1, w2, w3;
    t  = {SBOX[k[23:16]] ^ rcon(rnd), SBOX[k[15:8]], SBOX[k[7:0]], SBOX[k[31:24]]};
    w0 = k[127:96] ^ t;
    w1 = k[95:64] ^ w0;
    w2 = k[63:32] ^ w1;
    w3 = k[31:0] ^ w2;
    return {w0, w1, w2, w3};
  endfunction

  // SubBytes, ShiftRows and, unless final, MixColumns; byte 0 is the MSB.
  function automatic logic [127:0] aes_round(input logic [127:0] s, input logic fin);
    logic [7:0]   t [16];
    logic [7:0]   b [16];
    logic [7:0]   a0, a1, a2, a3;
    logic [127:0] r;
    for (int i = 0; i < 16; i++) t[i] = SBOX[s[127-8*i -: 8]];
    for (int c = 0; c < 4; c++)
      for (int i = 0; i < 4; i++) b[i+4*c] = t[i+4*((c+i)%4)];
    if (!fin) begin
      for (int c = 0; c < 4; c++) begin
        a0 = b[4*c]; a1 = b[4*c+1]; a2 = b[4*c+2]; a3 = b[4*c+3];
        b[4*c]   = xtime(a0) ^ xtime(a1) ^ a1 ^ a2 ^ a3;
        b[4*c+1] = a0 ^ xtime(a1) ^ xtime(a2) ^ a2 ^ a3;
        b[4*c+2] = a0 ^ a1 ^ xtime(a2) ^ xtime(a3) ^ a3;
        b[4*c+3] = xtime(a0) ^ a0 ^ a1 ^ a2 ^ xtime(a3);
      end
    end
    for (int i = 0; i < 16; i++) r[127-8*i -: 8] = b[i];
    return r;
  endfunction

endpackage

@@ hdl/axm_ifs.sv @@
// Request channel interfaces: message blocks in, authentication codes out.
interface axm_in_if;
  logic        valid;
  logic        ready;
  logic [63:0] block_high;
  logic [63:0] block_low;
  logic [4:0]  valid_bytes;
  logic        msg_end;
  modport source  (output valid, block_high, block_low, valid_bytes, msg_end, input ready);
  modport sink    (input valid, block_high, block_low, valid_bytes, msg_end, output ready);
  modport monitor (input valid, ready, block_high, block_low, valid_bytes, msg_end);
endinterface

interface axm_out_if;
  logic        valid;
  logic        ready;
  logic [63:0] mac_high;
  logic [63:0] mac_low;
  modport source  (output valid, mac_high, mac_low, input ready);
  modport sink    (input valid, mac_high, mac_low, output ready);
  modport monitor (input valid, ready, mac_high, mac_low);
endinterface

@@ hdl/axm_ctrl.sv @@
// Sequencer of the XCBC MAC block: subkey derivation, block chaining, result hand-off.
module axm_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               key_wr_i,
  input  logic               in_valid_i,
  input  logic               in_last_i,
  output logic               in_ready_o,
  input  logic               out_ready_i,
  output logic               out_valid_o,
  output axm_pkg::axm_cmd_t  cmd_o,
  input  axm_pkg::axm_sts_t  sts_i
);

  axm_pkg::axm_state_e state_q, state_d;
  logic       ready_q, ready_d;
  logic [1:0] sk_q, sk_d;
  logic       last_q, last_d;
  logic       out_valid_q, out_valid_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= axm_pkg::ST_IDLE;
      ready_q     <= 1'b0;
      sk_q        <= axm_pkg::SK_ONE;
      last_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      ready_q     <= ready_d;
      sk_q        <= sk_d;
      last_q      <= last_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_ready_o  = (state_q == axm_pkg::ST_IDLE) && ready_q;
  assign out_valid_o = out_valid_q;

  always_comb begin
    state_d = state_q;
    ready_d = ready_q;
    sk_d    = sk_q;
    last_d  = last_q;
    cmd_o   = '0;
    unique case (state_q)
      axm_pkg::ST_IDLE: begin
        if (!ready_q) begin
          sk_d    = axm_pkg::SK_ONE;
          state_d = axm_pkg::ST_DLOAD;
        end else if (in_valid_i) begin
          cmd_o.ld_block = 1'b1;
          last_d         = in_last_i;
          state_d        = axm_pkg::ST_RUN;
        end
      end
      axm_pkg::ST_DLOAD: begin
        cmd_o.ld_const = 1'b1;
        cmd_o.sk_sel   = sk_q;
        state_d        = axm_pkg::ST_DERIVE;
      end
      axm_pkg::ST_DERIVE: begin
        cmd_o.round_en = 1'b1;
        cmd_o.sk_sel   = sk_q;
        if (sts_i.last_round) begin
          cmd_o.store_sub = 1'b1;
          if (sk_q == axm_pkg::SK_THREE) begin
            ready_d = 1'b1;
            state_d = axm_pkg::ST_IDLE;
          end else begin
            sk_d    = sk_q + 2'd1;
            state_d = axm_pkg::ST_DLOAD;
          end
        end
      end
      axm_pkg::ST_RUN: begin
        cmd_o.round_en = 1'b1;
        if (sts_i.last_round) begin
          if (last_q) begin
            state_d = axm_pkg::ST_FIN;
          end else begin
            cmd_o.store_chain = 1'b1;
            state_d           = axm_pkg::ST_IDLE;
          end
        end
      end
      axm_pkg::ST_FIN: begin
        // hold the code until the output register is free
        if (!out_valid_q || out_ready_i) begin
          cmd_o.store_mac = 1'b1;
          cmd_o.clr_chain = 1'b1;
          state_d         = axm_pkg::ST_IDLE;
        end
      end
      default: state_d = axm_pkg::ST_IDLE;
    endcase
    if (key_wr_i) begin
      // drop the message in progress and derive again
      ready_d = 1'b0;
      state_d = axm_pkg::ST_IDLE;
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.store_mac)  out_valid_d = 1'b1;
    else if (out_ready_i) out_valid_d = 1'b0;
  end

endmodule

@@ hdl/axm_dp.sv @@
// Datapath of the XCBC MAC block: iterative AES-128 round unit and subkey store.
module axm_dp #(
  parameter int unsigned MAC_BYTES = 12
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               key_hi_wr_i,
  input  logic               key_lo_wr_i,
  input  logic [63:0]        cfg_data_i,
  input  logic [63:0]        block_high_i,
  input  logic [63:0]        block_low_i,
  input  logic [4:0]         valid_bytes_i,
  input  logic               msg_end_i,
  input  axm_pkg::axm_cmd_t  cmd_i,
  output axm_pkg::axm_sts_t  sts_o,
  output logic [63:0]        mac_high_o,
  output logic [63:0]        mac_low_o
);

  logic [127:0] key_q, chain_q;
  logic [127:0] k1_q, k2_q, k3_q;
  logic [127:0] state_q, state_d;
  logic [127:0] rkey_q, rkey_d;
  logic [127:0] mac_q;
  logic [3:0]   rnd_q, rnd_d;

  logic [127:0] nkey, nstate, const_pt, raw, blk, pt_blk, keep;
  logic [7:0]   cbyte;
  logic [4:0]   n;

  assign sts_o.last_round = (rnd_q == 4'(axm_pkg::LastRound));

  always_comb begin
    nkey   = axm_pkg::key_next(rkey_q, rnd_q);
    nstate = axm_pkg::aes_round(state_q, sts_o.last_round) ^ nkey;
  end

  assign cbyte    = {6'd0, cmd_i.sk_sel} + 8'd1;
  assign const_pt = {16{cbyte}};
  assign raw      = {block_high_i, block_low_i};

  // Pad a final block: keep bytes below the count, then 0x80, then zeros.
  always_comb begin
    n = (valid_bytes_i > 5'd16) ? 5'd16 : valid_bytes_i;
    for (int i = 0; i < 16; i++) begin
      if (!msg_end_i || n == 5'd16 || 5'(i) < n)
        blk[127-8*i -: 8] = raw[127-8*i -: 8];
      else if (5'(i) == n)
        blk[127-8*i -: 8] = 8'h80;
      else
        blk[127-8*i -: 8] = 8'h00;
    end
    if (!msg_end_i)      pt_blk = blk ^ chain_q;
    else if (n == 5'd16) pt_blk = blk ^ chain_q ^ k2_q;
    else                 pt_blk = blk ^ chain_q ^ k3_q;
  end

  always_comb begin
    for (int i = 0; i < 16; i++) keep[127-8*i -: 8] = (i < MAC_BYTES) ? 8'hff : 8'h00;
  end

  always_comb begin
    state_d = state_q;
    rkey_d  = rkey_q;
    rnd_d   = rnd_q;
    if (cmd_i.ld_const) begin
      state_d = const_pt ^ key_q;
      rkey_d  = key_q;
      rnd_d   = 4'd1;
    end else if (cmd_i.ld_block) begin
      state_d = pt_blk ^ k1_q;
      rkey_d  = k1_q;
      rnd_d   = 4'd1;
    end else if (cmd_i.round_en) begin
      state_d = nstate;
      rkey_d  = nkey;
      rnd_d   = rnd_q + 4'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rnd_q   <= 4'd0;
      key_q   <= '0;
      chain_q <= '0;
    end else begin
      rnd_q <= rnd_d;
      if (key_hi_wr_i) key_q[127:64] <= cfg_data_i;
      if (key_lo_wr_i) key_q[63:0]   <= cfg_data_i;
      if (key_hi_wr_i || key_lo_wr_i || cmd_i.clr_chain) chain_q <= '0;
      else if (cmd_i.store_chain)                          chain_q <= nstate;
    end
  end

  always_ff @(posedge clk_i) begin
    state_q <= state_d;
    rkey_q  <= rkey_d;
    if (cmd_i.store_sub) begin
      unique case (cmd_i.sk_sel)
        axm_pkg::SK_ONE:   k1_q <= nstate;
        axm_pkg::SK_TWO:   k2_q <= nstate;
        axm_pkg::SK_THREE: k3_q <= nstate;
        default:           k1_q <= k1_q;
      endcase
    end
    if (cmd_i.store_mac) mac_q <= state_q & keep;
  end

  assign mac_high_o = mac_q[127:64];
  assign mac_low_o  = mac_q[63:0];

endmodule

@@ hdl/aes_xcbc_message_auth.sv @@
// Top level of the AES-128 XCBC-MAC-96 message authentication block.
// Messages arrive as 128-bit blocks on in_ch, one request per block, and
// the code leaves on out_ch after the block flagged msg_end. A single
// AES round unit does all the work, one round per cycle with the round key
// expanded alongside: a block is loaded and then runs ten rounds, and a
// final block then moves the code into the output register, waiting while
// that register is still full. The block accepts the next request while a
// code still waits in that register. After reset and after every key write
// the three subkeys are derived before the first block is taken: three
// encryptions, with in_ch.ready low. A key write (index 0 high half, index
// 1 low half) drops any message in progress; other indices are ignored.
// valid_bytes above 16 counts as 16; it matters on the final block only: a
// short one is padded with 0x80 and zeros and mixed with the third subkey,
// a full one with the second. Bytes of the code from MAC_BYTES on are zero.
module aes_xcbc_message_auth #(
  parameter int unsigned MAC_BYTES = 12
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [axm_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [63:0]                  cfg_data_i,
  axm_in_if.sink                       in_ch,
  axm_out_if.source                    out_ch
);

  axm_pkg::axm_cmd_t cmd;
  axm_pkg::axm_sts_t sts;
  logic key_hi_wr, key_lo_wr;

  // decode key writes; both halves restart derivation
  assign key_hi_wr = cfg_we_i && (cfg_idx_i == axm_pkg::CFG_KEY_HIGH);
  assign key_lo_wr = cfg_we_i && (cfg_idx_i == axm_pkg::CFG_KEY_LOW);

  axm_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .key_wr_i    (key_hi_wr || key_lo_wr),
    .in_valid_i  (in_ch.valid),
    .in_last_i   (in_ch.msg_end),
    .in_ready_o  (in_ch.ready),
    .out_ready_i (out_ch.ready),
    .out_valid_o (out_ch.valid),
    .cmd_o       (cmd),
    .sts_i       (sts)
  );

  axm_dp #(.MAC_BYTES(MAC_BYTES)) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .key_hi_wr_i   (key_hi_wr),
    .key_lo_wr_i   (key_lo_wr),
    .cfg_data_i    (cfg_data_i),
    .block_high_i  (in_ch.block_high),
    .block_low_i   (in_ch.block_low),
    .valid_bytes_i (in_ch.valid_bytes),
    .msg_end_i     (in_ch.msg_end),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .mac_high_o    (out_ch.mac_high),
    .mac_low_o     (out_ch.mac_low)
  );

endmodule

@@ hdl/axm_checker.sv @@
// Port-level checker of the XCBC MAC block and its binding.
`include "aes_xcbc_message_auth_macros.svh"

module axm_checker #(
  parameter int unsigned MAC_BYTES = 12
) (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        cfg_we_i,
  input logic [axm_pkg::CfgIdxW-1:0] cfg_idx_i,
  input logic                        in_valid_i,
  input logic                        in_ready_i,
  input logic                        out_valid_i,
  input logic                        out_ready_i,
  input logic [63:0]                 mac_high_i,
  input logic [63:0]                 mac_low_i
);

  logic [127:0] drop_mask;
  logic         key_wr;

  always_comb begin
    for (int i = 0; i < 16; i++) drop_mask[127-8*i -: 8] = (i < MAC_BYTES) ? 8'h00 : 8'hff;
  end

  assign key_wr = cfg_we_i &&
                  (cfg_idx_i == axm_pkg::CFG_KEY_HIGH || cfg_idx_i == axm_pkg::CFG_KEY_LOW);

  `AXM_ASSERT_NEXT(a_out_hold, out_valid_i && !out_ready_i, out_valid_i, "code dropped while stalled")
  `AXM_ASSERT_NEXT(a_one_at_a_time, in_valid_i && in_ready_i, !in_ready_i, "request taken mid-block")
  `AXM_ASSERT_NEXT(a_key_rederive, key_wr, !in_ready_i, "request taken before subkey derivation")
  `AXM_ASSERT_NOW(a_trunc, out_valid_i, (({mac_high_i, mac_low_i} & drop_mask) == '0), "untruncated code")

endmodule

bind aes_xcbc_message_auth axm_checker #(.MAC_BYTES(MAC_BYTES)) u_axm_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .cfg_we_i    (cfg_we_i),
  .cfg_idx_i   (cfg_idx_i),
  .in_valid_i  (in_ch.valid),
  .in_ready_i  (in_ch.ready),
  .out_valid_i (out_ch.valid),
  .out_ready_i (out_ch.ready),
  .mac_high_i  (out_ch.mac_high),
  .mac_low_i   (out_ch.mac_low)
);
